FILE: design/pba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pba_pkg;

  localparam int PARTICLES_DEF = 32;
  localparam int FRACTION_BITS_DEF = 6;
  localparam int POS_W = 22;
  localparam int SPDX_W = 8;
  localparam int SPDY_W = 16;

  localparam logic CMD_LAUNCH = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [1:0] CFG_BG      = 2'd0;
  localparam logic [1:0] CFG_VSPEED  = 2'd1;
  localparam logic [1:0] CFG_GRAVITY = 2'd2;

  typedef struct packed {
    logic        command;
    logic [9:0]  start_x;
    logic [9:0]  start_y;
    logic [15:0] draw_colour;
    logic [15:0] burst_ticks;
    logic [31:0] draw_mask;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [15:0]        pixel_colour;
    logic [15:0]        time_left;
    logic               last;
  } out_item_t;

  // Control for the cells in the chain; launch and shift are shared by all cells.
  typedef struct packed {
    logic launch;
    logic shift;
    logic move;
  } cell_ctrl_t;

  // Quarter-wave sine, 64 = 1.0.
  function automatic logic [6:0] sine_q(input logic [3:0] i);
    logic [6:0] v;
    begin
      case (i)
        4'd0: v = 7'd0;
        4'd1: v = 7'd12;
        4'd2: v = 7'd24;
        4'd3: v = 7'd36;
        4'd4: v = 7'd45;
        4'd5: v = 7'd53;
        4'd6: v = 7'd59;
        4'd7: v = 7'd63;
        4'd8: v = 7'd64;
        default: v = 7'd0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

FILE: design/pba_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One particle slot. Slots form a ring; on shift each takes its neighbor's
// state, optionally advanced by one tick of motion.
module pba_cell (
  input  wire logic                                    clk,
  input  wire pba_pkg::cell_ctrl_t                     ctrl,
  input  wire logic signed [pba_pkg::POS_W-1:0]        launch_x,
  input  wire logic signed [pba_pkg::POS_W-1:0]        launch_y,
  input  wire logic signed [pba_pkg::SPDX_W-1:0]       launch_vx,
  input  wire logic signed [pba_pkg::SPDY_W-1:0]       launch_vy,
  input  wire logic signed [7:0]                       gravity,
  input  wire logic signed [pba_pkg::POS_W-1:0]        prev_px,
  input  wire logic signed [pba_pkg::POS_W-1:0]        prev_py,
  input  wire logic signed [pba_pkg::SPDX_W-1:0]       prev_vx,
  input  wire logic signed [pba_pkg::SPDY_W-1:0]       prev_vy,
  output logic signed [pba_pkg::POS_W-1:0]             px_r,
  output logic signed [pba_pkg::POS_W-1:0]             py_r,
  output logic signed [pba_pkg::SPDX_W-1:0]            vx_r,
  output logic signed [pba_pkg::SPDY_W-1:0]            vy_r
);
  import pba_pkg::*;

  localparam logic signed [POS_W:0] PMAX = (POS_W+1)'((1 << (POS_W-1)) - 1);
  localparam logic signed [POS_W:0] PMIN = -(POS_W+1)'(1 << (POS_W-1));
  localparam logic signed [SPDY_W:0] VMAX = (SPDY_W+1)'((1 << (SPDY_W-1)) - 1);
  localparam logic signed [SPDY_W:0] VMIN = -(SPDY_W+1)'(1 << (SPDY_W-1));

  logic signed [POS_W:0]  sx, sy;
  logic signed [SPDY_W:0] sv;
  logic signed [POS_W-1:0]  nx, ny;
  logic signed [SPDY_W-1:0] nv;

  // Saturating motion update of the neighbor's particle.
  always_comb begin
    sx = {prev_px[POS_W-1], prev_px} + (POS_W+1)'(prev_vx);
    sy = {prev_py[POS_W-1], prev_py} + (POS_W+1)'(prev_vy);
    sv = {prev_vy[SPDY_W-1], prev_vy} + (SPDY_W+1)'(gravity);
    nx = (sx > PMAX) ? PMAX[POS_W-1:0] : (sx < PMIN) ? PMIN[POS_W-1:0] : sx[POS_W-1:0];
    ny = (sy > PMAX) ? PMAX[POS_W-1:0] : (sy < PMIN) ? PMIN[POS_W-1:0] : sy[POS_W-1:0];
    nv = (sv > VMAX) ? VMAX[SPDY_W-1:0] : (sv < VMIN) ? VMIN[SPDY_W-1:0] : sv[SPDY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.launch) begin
      px_r <= launch_x;
      py_r <= launch_y;
      vx_r <= launch_vx;
      vy_r <= launch_vy;
    end else if (ctrl.shift) begin
      if (ctrl.move) begin
        px_r <= nx;
        py_r <= ny;
        vy_r <= nv;
      end else begin
        px_r <= prev_px;
        py_r <= prev_py;
        vy_r <= prev_vy;
      end
      vx_r <= prev_vx;
    end
  end

endmodule
`default_nettype wire

FILE: design/particle_burst_animator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Launch: accepted while idle, no results; the block stays idle and ready.
// Tick: 32 erase items, then, while time remains, a moving pass with up to 32
// drawn items; one slot per cycle, unless the output stalls, as the ring of
// particle cells rotates. An accepted tick sets the state register to erase,
// then the output register loads; input waits for both passes and any stalls.
// Synchronous active-low reset clears control and all particles and sets config defaults.
module particle_burst_animator_top #(
  parameter int PARTICLES     = pba_pkg::PARTICLES_DEF,
  parameter int FRACTION_BITS = pba_pkg::FRACTION_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pba_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pba_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import pba_pkg::*;

  localparam int CW = $clog2(PARTICLES);
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ERASE = 2'd1;
  localparam logic [1:0] S_DRAW  = 2'd2;
  localparam logic [1:0] S_INIT  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [15:0]        bg_r;
  logic signed [10:0] ivs_r;
  logic signed [7:0]  grav_r;
  logic [15:0]        time_r;
  logic [15:0]        tcur_r;
  logic [15:0]        colour_r;
  logic [31:0]        mask_r;
  out_item_t          out_r;
  logic               ov_r;

  logic signed [POS_W-1:0]  px  [PARTICLES];
  logic signed [POS_W-1:0]  py  [PARTICLES];
  logic signed [SPDX_W-1:0] vx  [PARTICLES];
  logic signed [SPDY_W-1:0] vy  [PARTICLES];
  logic signed [SPDY_W-1:0] lvy [PARTICLES];
  logic signed [SPDX_W-1:0] lvx [PARTICLES];
  cell_ctrl_t               ctrl;
  logic                     emit, can_out, init_pass, out_load;
  logic signed [POS_W-1:0]  lx, ly;
  logic signed [POS_W-1:0]  hx, hy;
  logic signed [POS_W-1:0]  shx, shy;

  assign can_out  = !ov_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && rst_n;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_data  = out_r;

  // Launch position: pixels scaled into fixed point, always in range.
  assign lx = POS_W'({in_data.start_x, FRACTION_BITS'(0)});
  assign ly = POS_W'({in_data.start_y, FRACTION_BITS'(0)});

  // Launch velocities per direction, fixed by slot, plus the configured offset on vy.
  for (genvar k = 0; k < PARTICLES; k++) begin : g_dir
    localparam int Q = k / 8;
    localparam int R = k % 8;
    logic signed [7:0] sx0, sy0;
    logic signed [SPDY_W:0] s;
    always_comb begin
      case (Q)
        0: begin sx0 = 8'(sine_q(4'(8 - R)));  sy0 = 8'(sine_q(4'(R))); end
        1: begin sx0 = -8'(sine_q(4'(R)));     sy0 = 8'(sine_q(4'(8 - R))); end
        2: begin sx0 = -8'(sine_q(4'(8 - R))); sy0 = -8'(sine_q(4'(R))); end
        default: begin sx0 = 8'(sine_q(4'(R))); sy0 = -8'(sine_q(4'(8 - R))); end
      endcase
      s = (SPDY_W+1)'(sy0) + (SPDY_W+1)'(ivs_r);
      lvx[k] = SPDX_W'(sx0);
      lvy[k] = s[SPDY_W-1:0];
    end
  end

  // Ring of cells; head is slot 0, data rotates toward lower slots.
  assign ctrl.launch = (in_valid && in_ready && in_data.command == CMD_LAUNCH) || init_pass;
  assign ctrl.shift  = emit;
  assign ctrl.move   = (state_r == S_DRAW);
  assign init_pass   = (state_r == S_INIT);

  for (genvar k = 0; k < PARTICLES; k++) begin : g_cell
    localparam int NXT = (k + 1) % PARTICLES;
    cell_ctrl_t cctrl;
    // Only the slot fed from the head applies motion, so each particle moves
    // once per pass.
    assign cctrl.launch = ctrl.launch;
    assign cctrl.shift  = ctrl.shift;
    assign cctrl.move   = (k == PARTICLES - 1) ? ctrl.move : 1'b0;
    pba_cell u_cell (
      .clk(clk), .ctrl(cctrl),
      .launch_x(init_pass ? '0 : lx), .launch_y(init_pass ? '0 : ly),
      .launch_vx(init_pass ? '0 : lvx[k]), .launch_vy(init_pass ? '0 : lvy[k]),
      .gravity(grav_r),
      .prev_px(px[NXT]), .prev_py(py[NXT]), .prev_vx(vx[NXT]), .prev_vy(vy[NXT]),
      .px_r(px[k]), .py_r(py[k]), .vx_r(vx[k]), .vy_r(vy[k])
    );
  end

  // Head cell holds the particle being emitted; in a draw pass the moved
  // value is what slot PARTICLES-1 receives, computed here once more.
  logic signed [POS_W:0] mx, my;
  localparam logic signed [POS_W:0] PMAX = (POS_W+1)'((1 << (POS_W-1)) - 1);
  localparam logic signed [POS_W:0] PMIN = -(POS_W+1)'(1 << (POS_W-1));
  always_comb begin
    mx = {px[0][POS_W-1], px[0]} + (POS_W+1)'(vx[0]);
    my = {py[0][POS_W-1], py[0]} + (POS_W+1)'(vy[0]);
    hx = (mx > PMAX) ? PMAX[POS_W-1:0] : (mx < PMIN) ? PMIN[POS_W-1:0] : mx[POS_W-1:0];
    hy = (my > PMAX) ? PMAX[POS_W-1:0] : (my < PMIN) ? PMIN[POS_W-1:0] : my[POS_W-1:0];
    if (state_r == S_DRAW) begin
      shx = hx >>> FRACTION_BITS;
      shy = hy >>> FRACTION_BITS;
    end else begin
      shx = px[0] >>> FRACTION_BITS;
      shy = py[0] >>> FRACTION_BITS;
    end
  end

  // One slot per cycle while the output register can take an item.
  assign emit = ((state_r == S_ERASE) || (state_r == S_DRAW)) && can_out;
  assign out_load = emit && ((state_r == S_ERASE) || mask_r[cnt_r]);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_data.command == CMD_TICK) begin
          state_nxt = S_ERASE;
          cnt_nxt   = '0;
        end
      end
      S_ERASE: begin
        if (emit) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CW'(PARTICLES - 1)) begin
            state_nxt = (tcur_r != 16'd0) ? S_DRAW : S_IDLE;
          end
        end
      end
      S_DRAW: begin
        if (emit) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CW'(PARTICLES - 1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_INIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      cnt_r    <= '0;
      bg_r     <= '0;
      ivs_r    <= -11'sd128;
      grav_r   <= 8'sd1;
      time_r   <= '0;
      colour_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_BG:      bg_r   <= cfg_data;
          CFG_VSPEED:  ivs_r  <= cfg_data[10:0];
          CFG_GRAVITY: grav_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.command == CMD_LAUNCH) begin
          colour_r <= in_data.draw_colour;
          time_r   <= in_data.burst_ticks;
        end else begin
          tcur_r <= time_r;
          mask_r <= in_data.draw_mask;
        end
      end
      if (state_r == S_DRAW && emit && cnt_r == CW'(PARTICLES - 1)) begin
        time_r <= time_r - 16'd1;
      end
      // A new item replaces or keeps the register full; otherwise it empties
      // when taken.
      ov_r <= out_load || (ov_r && !out_ready);
    end
  end

  // Output register payload; last is the final erase when no drawn item follows
  // (no time left or an empty mask), or the highest set mask bit of a draw pass.
  logic [31:0] rest;
  assign rest = (32'hFFFF_FFFE << cnt_r);
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.pixel_x   <= shx[15:0];
      out_r.pixel_y   <= shy[15:0];
      out_r.time_left <= tcur_r;
      if (state_r == S_ERASE) begin
        out_r.pixel_colour <= bg_r;
        out_r.last <= (cnt_r == CW'(PARTICLES - 1)) &&
                      ((tcur_r == 16'd0) || (mask_r == 32'd0));
      end else begin
        out_r.pixel_colour <= colour_r;
        out_r.last <= ((mask_r & rest) == 32'd0);
      end
    end
  end

endmodule
`default_nettype wire

FILE: tb/particle_burst_animator_top_tb.sv
`timescale 1ns / 1ps
module particle_burst_animator_top_tb;
  import pba_pkg::*;

  localparam int FB = FRACTION_BITS_DEF;
  localparam int NPART = PARTICLES_DEF;
  localparam int POS_HI = 2097151;
  localparam int POS_LO = -2097152;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_BG;
  logic [15:0] cfg_data = '0;

  particle_burst_animator_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the burst state and the registers.
  logic [15:0] bg_colour = 16'd0;
  int          vspeed_ofs = -128;
  int          grav = 1;
  int          pos_x [NPART];
  int          pos_y [NPART];
  int          spd_x [NPART];
  int          spd_y [NPART];
  logic [15:0] ticks_left = 16'd0;
  logic [15:0] burst_col = 16'd0;
  int          sine_tab [9] = '{0, 12, 24, 36, 45, 53, 59, 63, 64};

  out_item_t   pixel_q[$];
  int          errors = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  function automatic int clamp(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic out_item_t make_pixel(int px, int py, logic [15:0] col, logic [15:0] t);
    out_item_t p;
    int sx, sy;
    sx = px >>> FB;
    sy = py >>> FB;
    p.pixel_x = sx[15:0];
    p.pixel_y = sy[15:0];
    p.pixel_colour = col;
    p.time_left = t;
    p.last = 1'b0;
    return p;
  endfunction

  // Advance the shadow state by one item and queue the pixels it yields.
  task automatic predict_pixels(input in_item_t it);
    out_item_t   burst[$];
    int          vx, vy;
    logic [15:0] t;
    if (it.command == CMD_LAUNCH) begin
      for (int k = 0; k < NPART; k++) begin
        if (k < 8) begin
          vx = sine_tab[8 - k];  vy = sine_tab[k];
        end else if (k < 16) begin
          vx = -sine_tab[k - 8]; vy = sine_tab[16 - k];
        end else if (k < 24) begin
          vx = -sine_tab[24 - k]; vy = -sine_tab[k - 16];
        end else begin
          vx = sine_tab[k - 24]; vy = -sine_tab[32 - k];
        end
        pos_x[k] = int'(it.start_x) << FB;
        pos_y[k] = int'(it.start_y) << FB;
        spd_x[k] = vx;
        spd_y[k] = clamp(vy + vspeed_ofs, -32768, 32767);
      end
      burst_col = it.draw_colour;
      ticks_left = it.burst_ticks;
    end else begin
      t = ticks_left;
      for (int k = 0; k < NPART; k++)
        burst.push_back(make_pixel(pos_x[k], pos_y[k], bg_colour, t));
      if (t != 0) begin
        for (int k = 0; k < NPART; k++) begin
          pos_x[k] = clamp(pos_x[k] + spd_x[k], POS_LO, POS_HI);
          pos_y[k] = clamp(pos_y[k] + spd_y[k], POS_LO, POS_HI);
          if (it.draw_mask[k])
            burst.push_back(make_pixel(pos_x[k], pos_y[k], burst_col, t));
          spd_y[k] = clamp(spd_y[k] + grav, -32768, 32767);
        end
        ticks_left = t - 16'd1;
      end
      burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) pixel_q.push_back(burst[i]);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Result checker and watchdog.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("particle_burst_animator_top verification failed");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("unexpected pixel, pixel_x", out_data.pixel_x, 0);
        end else begin
          want = pixel_q.pop_front();
          if (out_data.pixel_x !== want.pixel_x)
            report_mismatch("pixel_x", out_data.pixel_x, want.pixel_x);
          if (out_data.pixel_y !== want.pixel_y)
            report_mismatch("pixel_y", out_data.pixel_y, want.pixel_y);
          if (out_data.pixel_colour !== want.pixel_colour)
            report_mismatch("pixel_colour", out_data.pixel_colour, want.pixel_colour);
          if (out_data.time_left !== want.time_left)
            report_mismatch("time_left", out_data.time_left, want.time_left);
          if (out_data.last !== want.last)
            report_mismatch("last", out_data.last, want.last);
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic in_item_t launch_item(logic [9:0] x, logic [9:0] y,
                                           logic [15:0] col, logic [15:0] glow);
    in_item_t it;
    it = '0;
    it.command = CMD_LAUNCH;
    it.start_x = x;
    it.start_y = y;
    it.draw_colour = col;
    it.burst_ticks = glow;
    it.draw_mask = $urandom();
    return it;
  endfunction

  function automatic in_item_t tick_item(logic [31:0] mask);
    in_item_t it;
    it = '0;
    it.command = CMD_TICK;
    it.start_x = 10'($urandom());
    it.start_y = 10'($urandom());
    it.draw_colour = 16'($urandom());
    it.burst_ticks = 16'($urandom());
    it.draw_mask = mask;
    return it;
  endfunction

  function automatic in_item_t random_item();
    int r;
    logic [15:0] glow;
    r = $urandom_range(99);
    if (r < 15) begin
      r = $urandom_range(99);
      glow = (r < 10) ? 16'd0 : (r < 20) ? 16'($urandom()) : 16'($urandom_range(30, 1));
      return launch_item(10'($urandom()), 10'($urandom()), 16'($urandom()), glow);
    end
    r = $urandom_range(99);
    return tick_item(r < 5 ? 32'hFFFF_FFFF : r < 10 ? 32'h0 : $urandom());
  endfunction

  // Offer one item, with a random gap first, and predict it once accepted.
  task automatic send_item(input in_item_t it, output out_item_t first, output bit has_first);
    int before_n;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    before_n = pixel_q.size();
    predict_pixels(it);
    has_first = (pixel_q.size() > before_n);
    first = has_first ? pixel_q[before_n] : '0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_BG:      bg_colour = value;
      CFG_VSPEED:  vspeed_ofs = int'($signed(value[10:0]));
      CFG_GRAVITY: grav = int'($signed(value[7:0]));
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering items, let every pixel arrive and the last moving pass
  // finish, so that register writes never land in the middle of a tick.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0 || !in_ready) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    out_item_t first;
    bit has_first;
    for (int i = 0; i < n; i++) send_item(random_item(), first, has_first);
    wait_quiet();
  endtask

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t first;
  } stim_row_t;

  stim_row_t rows[$];

  initial begin
    stim_row_t row;
    out_item_t first;
    bit        has_first;

    // Directed rows; a typed first pixel is checked directly against the block.
    row.typed = 1; row.item = tick_item(32'hFFFF_FFFF);
    row.first = '{pixel_x: 0, pixel_y: 0, pixel_colour: 0, time_left: 0, last: 0};
    rows.push_back(row);
    row.typed = 0;
    row.item = launch_item(10'd0, 10'd0, 16'hFFFF, 16'd2);   rows.push_back(row);
    row.item = tick_item(32'hFFFF_FFFF);                     rows.push_back(row);
    row.item = tick_item(32'h0000_0000);                     rows.push_back(row);
    row.item = tick_item(32'hAAAA_AAAA);                     rows.push_back(row);
    row.item = launch_item(10'd1023, 10'd1023, 16'h1234, 16'd0); rows.push_back(row);
    row.typed = 1; row.item = tick_item(32'hFFFF_FFFF);
    row.first = '{pixel_x: 1023, pixel_y: 1023, pixel_colour: 0, time_left: 0, last: 0};
    rows.push_back(row);
    row.typed = 0;
    row.item = launch_item(10'd1023, 10'd0, 16'h0000, 16'hFFFF); rows.push_back(row);
    row.item = tick_item(32'hFFFF_FFFF);                     rows.push_back(row);
    row.item = tick_item(32'h5555_5555);                     rows.push_back(row);
    row.item = launch_item(10'd0, 10'd1023, 16'hFFFF, 16'd1); rows.push_back(row);
    row.item = tick_item(32'h8000_0001);                     rows.push_back(row);
    row.item = tick_item(32'h0000_0001);                     rows.push_back(row);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      send_item(rows[i].item, first, has_first);
      if (rows[i].typed && has_first) begin
        // The block is compared with the typed value instead of the prediction.
        if (first !== rows[i].first)
          report_mismatch("predicted first pixel row", i, i);
        pixel_q[pixel_q.size() - (rows[i].item.draw_mask == 32'hFFFF_FFFF &&
                                  first.time_left != 0 ? 64 : 32)] = rows[i].first;
      end
    end
    wait_quiet();

    // Strong upward launch, strongest downward pull, no idling.
    write_reg(CFG_BG, 16'hFFFF);
    write_reg(CFG_VSPEED, 16'hFC00);
    write_reg(CFG_GRAVITY, 16'h007F);
    run_random(80);

    // Opposite extremes with a mostly idle sender.
    idle_pct = 75;
    write_reg(CFG_BG, 16'h0000);
    write_reg(CFG_VSPEED, 16'h03FF);
    write_reg(CFG_GRAVITY, 16'h0080);
    run_random(80);

    // Random settings, a stalling receiver, and one long hold-off.
    idle_pct = 0;
    stall_pct = 75;
    write_reg(CFG_BG, 16'($urandom()));
    write_reg(CFG_VSPEED, 16'($urandom()));
    write_reg(CFG_GRAVITY, 16'($urandom()));
    hold_req = 1;
    run_random(80);

    // Both sides idling some of the time.
    idle_pct = 25;
    stall_pct = 25;
    write_reg(CFG_BG, 16'($urandom()));
    write_reg(CFG_VSPEED, 16'($urandom()));
    write_reg(CFG_GRAVITY, 16'($urandom()));
    run_random(80);

    // Back to the reset settings.
    idle_pct = 0;
    stall_pct = 0;
    write_reg(CFG_BG, 16'h0000);
    write_reg(CFG_VSPEED, 16'hFF80);
    write_reg(CFG_GRAVITY, 16'h0001);
    run_random(50);

    repeat (80) @(posedge clk);
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("particle_burst_animator_top verification clean");
    end else begin
      $display("particle_burst_animator_top verification failed");
    end
    $finish;
  end

endmodule
